// ===== design/lpse_pkg.sv =====
// ----------------------------------------------------------------------------
// lpse_pkg
// Shared types, constants and the line-bit expansion for the LED pixel encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

   localparam int PIXELS = 16;
   localparam int PIX_W  = $clog2(PIXELS);
   localparam int CNT_W  = $clog2(PIXELS + 1);

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 4;
   localparam int BYTE_W = 8;
   localparam int LINE_W = 3 * BYTE_W;
   localparam int RGB_W  = 3 * BYTE_W;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] PIXEL_COUNT_RESET = CFG_W'(16);

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SHOW  = 2'd2;

   typedef struct packed {
      logic req_ready;
      logic write_pixel;
      logic clear_store;
      logic start_show;
      logic load_pixel;
   } lpse_cmd_type;

   typedef struct packed {
      logic              req_valid;
      logic [FUNC_W-1:0] func;
      logic              index_ok;
      logic              count_zero;
      logic              slot_free;
      logic              last_pixel;
   } lpse_status_type;

   // Each data bit, MSB first, becomes 1,b,0 on the line.
   function automatic logic [LINE_W-1:0] expand_byte(input logic [BYTE_W-1:0] v);
      logic [LINE_W-1:0] line;
      line = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         line[3*i +: 3] = {1'b1, v[i], 1'b0};
      end
      return line;
   endfunction

endpackage

// ===== design/lpse_req_if.sv =====
// ----------------------------------------------------------------------------
// lpse_req_if
// Request channel: operation code and pixel operands.
// ----------------------------------------------------------------------------
interface lpse_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpse_pkg::FUNC_W-1:0]   func;
   logic [lpse_pkg::IDX_W-1:0]    pixel_index;
   logic [lpse_pkg::BYTE_W-1:0]   red;
   logic [lpse_pkg::BYTE_W-1:0]   green;
   logic [lpse_pkg::BYTE_W-1:0]   blue;

   modport source (output valid, func, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, func, pixel_index, red, green, blue, output ready);
endinterface

// ===== design/lpse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpse_rsp_if
// Response channel: one encoded pixel per transfer.
// ----------------------------------------------------------------------------
interface lpse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpse_pkg::IDX_W-1:0]    pixel_number;
   logic [lpse_pkg::LINE_W-1:0]   line_green;
   logic [lpse_pkg::LINE_W-1:0]   line_red;
   logic [lpse_pkg::LINE_W-1:0]   line_blue;
   logic                          frame_end;

   modport source (output valid, pixel_number, line_green, line_red, line_blue,
                   frame_end, input ready);
   modport sink   (input valid, pixel_number, line_green, line_red, line_blue,
                   frame_end, output ready);
endinterface

// ===== design/lpse_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpse_ctrl
// Controller: decodes requests and sequences the show walk.
// ----------------------------------------------------------------------------
module lpse_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  lpse_pkg::lpse_status_type  status,
   output lpse_pkg::lpse_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SHOW = 2'b10
   } lpse_state_type;

   lpse_state_type state_ff, state_in;
   logic           accept;

   assign accept = status.req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.req_ready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (status.func)
                  lpse_pkg::FUNC_SET: begin
                     cmd.write_pixel = status.index_ok;
                  end
                  lpse_pkg::FUNC_CLEAR: begin
                     cmd.clear_store = 1'b1;
                  end
                  lpse_pkg::FUNC_SHOW: begin
                     if (!status.count_zero) begin
                        cmd.start_show = 1'b1;
                        state_in       = ST_SHOW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHOW: begin
            // advance one pixel whenever the output register can take it
            if (status.slot_free) begin
               cmd.load_pixel = 1'b1;
               if (status.last_pixel) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lpse_datapath.sv =====
// ----------------------------------------------------------------------------
// lpse_datapath
// Datapath: pixel count, colour store, walk pointer and output register.
// ----------------------------------------------------------------------------
module lpse_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lpse_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   input  logic [lpse_pkg::FUNC_W-1:0]       req_func,
   input  logic [lpse_pkg::IDX_W-1:0]        req_pixel_index,
   input  logic [lpse_pkg::BYTE_W-1:0]       req_red,
   input  logic [lpse_pkg::BYTE_W-1:0]       req_green,
   input  logic [lpse_pkg::BYTE_W-1:0]       req_blue,
   input  lpse_pkg::lpse_cmd_type            cmd,
   output lpse_pkg::lpse_status_type         status,
   lpse_rsp_if.source                        rsp_ch
);

   logic [lpse_pkg::CFG_W-1:0]   pixel_count_ff;
   logic [lpse_pkg::CNT_W-1:0]   active_count;
   logic [lpse_pkg::RGB_W-1:0]   store_ff [lpse_pkg::PIXELS];
   logic [lpse_pkg::PIXELS-1:0]  entry_valid_ff;
   logic [lpse_pkg::PIX_W-1:0]   ptr_ff, ptr_in;
   logic [lpse_pkg::CNT_W-1:0]   ptr_plus_one;
   logic [lpse_pkg::PIX_W-1:0]   write_addr;
   logic [lpse_pkg::RGB_W-1:0]   entry;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpse_pkg::IDX_W-1:0]   pixel_number_ff;
   logic [lpse_pkg::LINE_W-1:0]  line_green_ff, line_red_ff, line_blue_ff;
   logic                         frame_end_ff;

   // clamp the count to the store depth
   assign active_count = (pixel_count_ff > lpse_pkg::CFG_W'(lpse_pkg::PIXELS))
                         ? lpse_pkg::CNT_W'(lpse_pkg::PIXELS)
                         : lpse_pkg::CNT_W'(pixel_count_ff);

   assign write_addr   = req_pixel_index[lpse_pkg::PIX_W-1:0];
   assign ptr_plus_one = lpse_pkg::CNT_W'(ptr_ff) + lpse_pkg::CNT_W'(1);
   assign entry        = entry_valid_ff[ptr_ff] ? store_ff[ptr_ff] : '0;

   always_comb begin
      status            = '0;
      status.req_valid  = req_valid;
      status.func       = req_func;
      status.index_ok   = (lpse_pkg::CNT_W'(req_pixel_index) < active_count);
      status.count_zero = (active_count == '0);
      status.slot_free  = !rsp_valid_ff || rsp_ch.ready;
      status.last_pixel = (ptr_plus_one == active_count);
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.start_show) begin
         ptr_in = '0;
      end else if (cmd.load_pixel) begin
         ptr_in = ptr_plus_one[lpse_pkg::PIX_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_pixel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= lpse_pkg::PIXEL_COUNT_RESET;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         ptr_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            pixel_count_ff <= csr_wr_data;
         end
         if (cmd.clear_store) begin
            entry_valid_ff <= '0;
         end else if (cmd.write_pixel) begin
            entry_valid_ff[write_addr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   // store entry layout: red, green, blue from the top
   always_ff @(posedge clock) begin
      if (cmd.write_pixel) begin
         store_ff[write_addr] <= {req_red, req_green, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pixel_number_ff <= lpse_pkg::IDX_W'(ptr_ff);
         line_green_ff   <= lpse_pkg::expand_byte(entry[15:8]);
         line_red_ff     <= lpse_pkg::expand_byte(entry[23:16]);
         line_blue_ff    <= lpse_pkg::expand_byte(entry[7:0]);
         frame_end_ff    <= status.last_pixel;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pixel_number = pixel_number_ff;
   assign rsp_ch.line_green   = line_green_ff;
   assign rsp_ch.line_red     = line_red_ff;
   assign rsp_ch.line_blue    = line_blue_ff;
   assign rsp_ch.frame_end    = frame_end_ff;

endmodule

// ===== design/led_pixel_spi_encoder.sv =====
// ----------------------------------------------------------------------------
// led_pixel_spi_encoder
// Pixel store and three-bit line encoder for a chain of addressable LEDs.
// ----------------------------------------------------------------------------
// A set-pixel or clear request is taken on its transfer, and the next request
// may follow in the next cycle. A show request walks the store one pixel per
// cycle, while the response side can take each pixel, through a single read
// pointer, starting after its transfer, so the next request is taken only once
// the walk over pixel_count pixels (count clamped to the store depth) is done;
// a show with a count of zero frees the request side at once. The request side
// is not ready during the walk. Responses come in pixel order from pixel 0,
// each carrying green, red and blue expanded so that every data bit, MSB first,
// is sent as 1,b,0 (0 -> 100, 1 -> 110); frame_end marks the last pixel. A
// registered output stage parts the two sides, so a new request is taken while
// the last response of a show still waits. Set-pixel to an index at or beyond
// the active count is dropped; a show with a count of zero and an unused
// operation code produce nothing. Clear and reset empty the store at once
// through per-entry valid bits, so there is no clearing pass. Write csr_wr_data
// (pixel count) only while idle.
// ----------------------------------------------------------------------------
module led_pixel_spi_encoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [lpse_pkg::CFG_W-1:0]  csr_wr_data,
   lpse_req_if.sink                    req_ch,
   lpse_rsp_if.source                  rsp_ch
);

   lpse_pkg::lpse_cmd_type     cmd;
   lpse_pkg::lpse_status_type  status;

   // hold off requests while the controller walks the store
   assign req_ch.ready = cmd.req_ready;

   lpse_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lpse_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_ch.valid),
      .req_func        (req_ch.func),
      .req_pixel_index (req_ch.pixel_index),
      .req_red         (req_ch.red),
      .req_green       (req_ch.green),
      .req_blue        (req_ch.blue),
      .cmd             (cmd),
      .status          (status),
      .rsp_ch          (rsp_ch)
   );

endmodule
